@@ rtl/core/gid_pkg.sv @@
package gid_pkg;

    // Number of strides that make up one calibration run.
    localparam int CAL_STEPS = 8;

    localparam int ANGLE_W = 16;
    localparam int THR_W   = 14;
    localparam int SUM_W   = 22;
    localparam int EST_W   = 2;
    localparam int CNT_W   = $clog2(CAL_STEPS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_INCLINE_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINE_THR = 1'd1;

    localparam logic [THR_W-1:0]   INCLINE_THR_RESET = 14'd1229;
    localparam logic [THR_W-1:0]   DECLINE_THR_RESET = 14'd3277;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET       = 16'd8192;

    // Reciprocal division of a sum by a fixed stride count. With
    // K = SUM_W + ceil(log2(divisor)) and M = ceil(2^K / divisor), the
    // product of a SUM_W-bit magnitude and M shifted right by K is the exact
    // floor quotient.
    localparam int DIV_K = SUM_W + $clog2(CAL_STEPS);
    localparam int REC_W = DIV_K + 1;

    localparam longint unsigned ENTRY_RECIP_L =
        ((64'd1 << DIV_K) + 64'(CAL_STEPS) - 64'd1) / 64'(CAL_STEPS);
    localparam longint unsigned EXIT_RECIP_L =
        ((64'd1 << DIV_K) + 64'(CAL_STEPS) - 64'd2) / 64'(CAL_STEPS - 1);

    localparam logic [REC_W-1:0] ENTRY_RECIP = ENTRY_RECIP_L[REC_W-1:0];
    localparam logic [REC_W-1:0] EXIT_RECIP  = EXIT_RECIP_L[REC_W-1:0];

    typedef enum logic [EST_W-1:0] {
        EST_LEVEL   = 2'd0,
        EST_INCLINE = 2'd1,
        EST_DECLINE = 2'd2
    } t_estimate;

    typedef struct packed {
        logic signed [SUM_W-1:0] entry_sum;
        logic signed [SUM_W-1:0] exit_sum;
    } t_calib_sums;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] entry_angle;
        logic signed [ANGLE_W-1:0] exit_angle;
    } t_calib_angles;

endpackage

@@ rtl/core/gid_calib.sv @@
module gid_calib (
    input  gid_pkg::t_calib_sums   i_sums,
    output gid_pkg::t_calib_angles o_angles
);

    localparam int PROD_W = gid_pkg::SUM_W + gid_pkg::REC_W;
    localparam int QUO_W  = gid_pkg::SUM_W + 1;

    logic [gid_pkg::SUM_W-1:0] entry_mag;
    logic [gid_pkg::SUM_W-1:0] exit_mag;
    logic [PROD_W-1:0]         entry_prod;
    logic [PROD_W-1:0]         exit_prod;
    logic signed [QUO_W-1:0]   entry_quo;
    logic signed [QUO_W-1:0]   exit_quo;

    function automatic logic signed [gid_pkg::ANGLE_W-1:0] sat_angle(
        input logic signed [QUO_W-1:0] value
    );
        logic signed [QUO_W-1:0] hi;
        logic signed [QUO_W-1:0] lo;
        hi = QUO_W'(32767);
        lo = -QUO_W'(32768);
        if (value > hi) begin
            return 16'sh7FFF;
        end else if (value < lo) begin
            return 16'sh8000;
        end
        return value[gid_pkg::ANGLE_W-1:0];
    endfunction

    // Divide the magnitude and restore the sign, which truncates toward zero.
    assign entry_mag = i_sums.entry_sum[gid_pkg::SUM_W-1] ?
                       gid_pkg::SUM_W'(-i_sums.entry_sum) : i_sums.entry_sum;
    assign exit_mag  = i_sums.exit_sum[gid_pkg::SUM_W-1] ?
                       gid_pkg::SUM_W'(-i_sums.exit_sum) : i_sums.exit_sum;

    assign entry_prod = PROD_W'(entry_mag) * PROD_W'(gid_pkg::ENTRY_RECIP);
    assign exit_prod  = PROD_W'(exit_mag) * PROD_W'(gid_pkg::EXIT_RECIP);

    always_comb begin
        entry_quo = $signed({1'b0, entry_prod[gid_pkg::DIV_K +: gid_pkg::SUM_W]});
        exit_quo  = $signed({1'b0, exit_prod[gid_pkg::DIV_K +: gid_pkg::SUM_W]});
        if (i_sums.entry_sum[gid_pkg::SUM_W-1]) begin
            entry_quo = -entry_quo;
        end
        if (i_sums.exit_sum[gid_pkg::SUM_W-1]) begin
            exit_quo = -exit_quo;
        end
        o_angles.entry_angle = sat_angle(entry_quo);
        o_angles.exit_angle  = sat_angle(exit_quo);
    end

endmodule

@@ rtl/core/gait_inclination_detector_top.sv @@
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------
// sample   | in        | i_valid / o_stall   | i_stance, i_sensor_calibrating,
//          |           |                     | i_angle
// estimate | out       | o_valid / i_stall   | o_estimate
// config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Every accepted sample beat produces exactly one estimate beat in the next cycle, and a
// new sample can be taken in every cycle that o_stall is low: one beat per cycle then.
// The longest path is the reciprocal multiply of the registered calibration sums
// followed by the threshold compare.
// Reset is synchronous and active low; it restores the default thresholds and
// calibrated angles and leaves calibration marked as finished. The input stalls only
// while the result register is full and the output is stalled.
module gait_inclination_detector_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_stance,
    input  logic                                 i_sensor_calibrating,
    input  logic signed [gid_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [gid_pkg::EST_W-1:0]            o_estimate,
    input  logic                                 i_cfg_we,
    input  logic [gid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gid_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CMP_W = gid_pkg::ANGLE_W + 2;
    localparam logic [gid_pkg::CNT_W-1:0] CNT_FULL = gid_pkg::CNT_W'(gid_pkg::CAL_STEPS);

    // Threshold registers.
    logic [gid_pkg::THR_W-1:0] r_incline_thr;
    logic [gid_pkg::THR_W-1:0] r_decline_thr;

    // Detector state.
    logic                              r_last_stance;
    logic                              r_last_cal;
    logic                              r_last_should;
    logic                              r_given;
    gid_pkg::t_estimate                r_last_est;
    logic [gid_pkg::CNT_W-1:0]         r_step_count;
    logic signed [gid_pkg::SUM_W-1:0]  r_entry_sum;
    logic signed [gid_pkg::SUM_W-1:0]  r_exit_sum;
    logic signed [gid_pkg::ANGLE_W-1:0] r_entry_angle;
    logic signed [gid_pkg::ANGLE_W-1:0] r_exit_angle;

    // Result register.
    logic                       r_out_valid;
    gid_pkg::t_estimate         r_out_est;

    logic                              n_last_should;
    logic                              n_given;
    gid_pkg::t_estimate                n_last_est;
    logic [gid_pkg::CNT_W-1:0]         n_step_count;
    logic signed [gid_pkg::SUM_W-1:0]  n_entry_sum;
    logic signed [gid_pkg::SUM_W-1:0]  n_exit_sum;
    logic signed [gid_pkg::ANGLE_W-1:0] n_entry_angle;
    logic signed [gid_pkg::ANGLE_W-1:0] n_exit_angle;
    logic                              n_out_valid;

    logic                         accept;
    logic                         rising;
    logic                         falling;
    logic                         cal_fall;
    logic [gid_pkg::CNT_W-1:0]    count_base;
    logic signed [gid_pkg::SUM_W-1:0] entry_base;
    logic signed [gid_pkg::SUM_W-1:0] exit_base;
    logic signed [gid_pkg::SUM_W-1:0] angle_ext;
    logic                         calib_now;
    logic                         incline_hit;
    logic                         decline_hit;
    logic signed [CMP_W-1:0]      angle_cmp;
    logic signed [CMP_W-1:0]      incline_lim;
    logic signed [CMP_W-1:0]      decline_lim;

    gid_pkg::t_calib_sums   calib_sums;
    gid_pkg::t_calib_angles calib_angles;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;
    assign o_valid = r_out_valid;
    assign o_estimate = r_out_est;

    // The calibrated angles are always derived from the registered sums. On
    // the beat that closes a calibration run no angle is added, so the
    // registered sums are already final.
    assign calib_sums.entry_sum = r_entry_sum;
    assign calib_sums.exit_sum  = r_exit_sum;

    gid_calib u_calib (
        .i_sums   (calib_sums),
        .o_angles (calib_angles)
    );

    assign rising    = i_stance && !r_last_stance;
    assign falling   = !i_stance && r_last_stance;
    assign cal_fall  = r_last_cal && !i_sensor_calibrating;
    assign angle_ext = gid_pkg::SUM_W'(i_angle);

    always_comb begin
        // A falling calibrating flag restarts the run before this beat's
        // stance edge is counted.
        count_base = cal_fall ? '0 : r_step_count;
        entry_base = cal_fall ? '0 : r_entry_sum;
        exit_base  = cal_fall ? '0 : r_exit_sum;

        n_step_count = count_base;
        if (falling && (count_base < CNT_FULL)) begin
            n_step_count = count_base + gid_pkg::CNT_W'(1);
        end
        n_last_should = n_step_count < CNT_FULL;

        n_entry_sum = entry_base;
        n_exit_sum  = exit_base;
        if (n_last_should && rising) begin
            n_entry_sum = entry_base + angle_ext;
        end
        if (n_last_should && falling) begin
            n_exit_sum = exit_base + angle_ext;
        end

        calib_now     = !n_last_should && r_last_should;
        n_entry_angle = calib_now ? calib_angles.entry_angle : r_entry_angle;
        n_exit_angle  = calib_now ? calib_angles.exit_angle  : r_exit_angle;

        angle_cmp   = CMP_W'(i_angle);
        incline_lim = CMP_W'(n_entry_angle) - $signed(CMP_W'(r_incline_thr));
        decline_lim = CMP_W'(n_exit_angle)  - $signed(CMP_W'(r_decline_thr));
        incline_hit = rising && (angle_cmp < incline_lim);
        decline_hit = angle_cmp < decline_lim;

        // A rising edge opens a new stride; an incline there settles it. If
        // it did not, the following falling edge reports decline or level.
        n_given    = rising ? incline_hit : r_given;
        n_last_est = r_last_est;
        if (incline_hit) begin
            n_last_est = gid_pkg::EST_INCLINE;
        end else if (falling && !n_given) begin
            n_last_est = decline_hit ? gid_pkg::EST_DECLINE : gid_pkg::EST_LEVEL;
        end

        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incline_thr <= gid_pkg::INCLINE_THR_RESET;
            r_decline_thr <= gid_pkg::DECLINE_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gid_pkg::CFG_INCLINE_THR: r_incline_thr <= i_cfg_data;
                gid_pkg::CFG_DECLINE_THR: r_decline_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stance <= 1'b1;
            r_last_cal    <= 1'b0;
            r_last_should <= 1'b0;
            r_given       <= 1'b1;
            r_last_est    <= gid_pkg::EST_LEVEL;
            r_step_count  <= CNT_FULL;
            r_entry_sum   <= '0;
            r_exit_sum    <= '0;
            r_entry_angle <= gid_pkg::ANGLE_RESET;
            r_exit_angle  <= gid_pkg::ANGLE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_last_stance <= i_stance;
                r_last_cal    <= i_sensor_calibrating;
                r_last_should <= n_last_should;
                r_given       <= n_given;
                r_last_est    <= n_last_est;
                r_step_count  <= n_step_count;
                r_entry_sum   <= n_entry_sum;
                r_exit_sum    <= n_exit_sum;
                r_entry_angle <= n_entry_angle;
                r_exit_angle  <= n_exit_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_est <= n_last_est;
        end
    end

`ifndef SYNTHESIS
    // The step count never runs past a full calibration run.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_count <= CNT_FULL)
        else $error("step count beyond calibration length");

    // The calibration flag always agrees with the step count.
    a_should_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_should == (r_step_count < CNT_FULL))
        else $error("calibration flag disagrees with step count");

    // Every accepted sample yields an estimate beat on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid && (o_estimate == $past(n_last_est)))
        else $error("accepted sample produced no estimate");

    // An accepted incline always leaves the stride marked as settled.
    a_incline_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && incline_hit) |=> r_given && (r_last_est == gid_pkg::EST_INCLINE))
        else $error("incline not recorded");
`endif

endmodule
